// ----- hdl/dffc_pkg.sv -----
// dffc_pkg: widths, codes and control structs of the direct-form fir convolver
// no dependencies; used by every other file in hdl
`default_nettype none

package dffc_pkg;

  localparam int unsigned TAPS   = 64;
  localparam int unsigned IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned TCMP_W = 11;

  localparam int unsigned SMP_W  = 16;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned CIDX_W = 6;
  localparam int unsigned SUM_W  = 38;

  localparam int unsigned DIG_W  = 4;
  localparam int unsigned NDIG   = SMP_W / DIG_W;
  localparam int unsigned DCNT_W = $clog2(NDIG);

  localparam int unsigned PP_W   = COEF_W + DIG_W + 1;
  localparam int unsigned PROD_W = COEF_W + SMP_W;
  localparam int unsigned ACC_RAW = PROD_W + 1 + IDX_W;
  localparam int unsigned ACC_W  = (ACC_RAW > SUM_W) ? ACC_RAW : SUM_W;

  localparam logic REQ_COEF   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic             coef_we;
    logic             smp_we;
    logic             hist_clr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_tap;
  } store_ctrl_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic mul;
    logic first_dig;
    logic add;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/dffc_if.sv -----
// request and result channel interfaces, valid/ready with payload
// depends on dffc_pkg
`default_nettype none

interface dffc_req_if;
  logic                                valid;
  logic                                ready;
  logic [0:0]                          req_type;
  logic [dffc_pkg::CIDX_W-1:0]         coef_index;
  logic signed [dffc_pkg::COEF_W-1:0]  coef_value;
  logic signed [dffc_pkg::SMP_W-1:0]   sample_value;
  logic [0:0]                          first_sample;

  modport source (output valid, req_type, coef_index, coef_value, sample_value, first_sample,
                  input ready);
  modport sink   (input valid, req_type, coef_index, coef_value, sample_value, first_sample,
                  output ready);
endinterface

interface dffc_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [dffc_pkg::SUM_W-1:0]  filtered_sum;

  modport source (output valid, filtered_sum, input ready);
  modport sink   (input valid, filtered_sum, output ready);
endinterface

`default_nettype wire

// ----- hdl/dffc_store.sv -----
// dffc_store: coefficient store and circular sample history, one read port each
// depends on dffc_pkg; entries with a clear valid bit read as zero
`default_nettype none

module dffc_store (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire dffc_pkg::store_ctrl_t             ctrl_i,
  input  wire logic [dffc_pkg::IDX_W-1:0]        coef_idx_i,
  input  wire logic signed [dffc_pkg::COEF_W-1:0] coef_val_i,
  input  wire logic signed [dffc_pkg::SMP_W-1:0]  smp_val_i,
  output logic signed [dffc_pkg::COEF_W-1:0]     coef_rd_o,
  output logic signed [dffc_pkg::SMP_W-1:0]      smp_rd_o
);

  localparam int unsigned IW = dffc_pkg::IDX_W;

  logic [dffc_pkg::COEF_W-1:0] coef_mem [dffc_pkg::TAPS];
  logic [dffc_pkg::SMP_W-1:0]  hist_mem [dffc_pkg::TAPS];

  logic [dffc_pkg::TAPS-1:0] coef_vld_q, coef_vld_d;
  logic [dffc_pkg::TAPS-1:0] hist_vld_q, hist_vld_d;
  logic [IW-1:0]             head_q, head_d;
  logic [IW-1:0]             head_nxt;
  logic [IW:0]               diff;
  logic [IW-1:0]             hist_addr;

  logic [dffc_pkg::COEF_W-1:0] coef_rd_q;
  logic [dffc_pkg::SMP_W-1:0]  smp_rd_q;
  logic                        coef_rv_q, coef_rv_d;
  logic                        smp_rv_q, smp_rv_d;

  assign head_nxt = (head_q == IW'(dffc_pkg::TAPS - 1)) ? '0 : IW'(head_q + 1'b1);

  // history entry j sits j places behind the head
  always_comb begin
    diff = {1'b0, head_q} - {1'b0, ctrl_i.rd_tap};
    if (diff[IW]) begin
      hist_addr = IW'(diff + (IW + 1)'(dffc_pkg::TAPS));
    end else begin
      hist_addr = diff[IW-1:0];
    end
  end

  always_comb begin
    coef_vld_d = coef_vld_q;
    hist_vld_d = hist_vld_q;
    head_d     = head_q;
    coef_rv_d  = coef_rv_q;
    smp_rv_d   = smp_rv_q;
    if (ctrl_i.coef_we) begin
      coef_vld_d[coef_idx_i] = 1'b1;
    end
    if (ctrl_i.smp_we) begin
      if (ctrl_i.hist_clr) begin
        hist_vld_d = '0;
      end
      hist_vld_d[head_nxt] = 1'b1;
      head_d               = head_nxt;
    end
    if (ctrl_i.rd_en) begin
      coef_rv_d = coef_vld_q[ctrl_i.rd_tap];
      smp_rv_d  = hist_vld_q[hist_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      hist_vld_q <= '0;
      head_q     <= '0;
      coef_rv_q  <= 1'b0;
      smp_rv_q   <= 1'b0;
    end else begin
      coef_vld_q <= coef_vld_d;
      hist_vld_q <= hist_vld_d;
      head_q     <= head_d;
      coef_rv_q  <= coef_rv_d;
      smp_rv_q   <= smp_rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.coef_we) begin
      coef_mem[coef_idx_i] <= coef_val_i;
    end
    if (ctrl_i.smp_we) begin
      hist_mem[head_nxt] <= smp_val_i;
    end
    if (ctrl_i.rd_en) begin
      coef_rd_q <= coef_mem[ctrl_i.rd_tap];
      smp_rd_q  <= hist_mem[hist_addr];
    end
  end

  assign coef_rd_o = coef_rv_q ? $signed(coef_rd_q) : '0;
  assign smp_rd_o  = smp_rv_q ? $signed(smp_rd_q) : '0;

endmodule

`default_nettype wire

// ----- hdl/dffc_mac.sv -----
// dffc_mac: digit-serial multiply-accumulate, sample shifted in 4-bit digits msb first
// depends on dffc_pkg; the accumulated sum is saturated to the result width at the output
`default_nettype none

module dffc_mac (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire dffc_pkg::mac_ctrl_t                ctrl_i,
  input  wire logic signed [dffc_pkg::COEF_W-1:0] coef_i,
  input  wire logic signed [dffc_pkg::SMP_W-1:0]  smp_i,
  output logic signed [dffc_pkg::SUM_W-1:0]       sum_o
);

  localparam int unsigned PW = dffc_pkg::PROD_W;
  localparam int unsigned AW = dffc_pkg::ACC_W;
  localparam int unsigned SW = dffc_pkg::SUM_W;
  localparam int unsigned DW = dffc_pkg::DIG_W;

  logic signed [dffc_pkg::COEF_W-1:0] coef_q, coef_d;
  logic [dffc_pkg::SMP_W-1:0]         sr_q, sr_d;
  logic signed [PW-1:0]               prod_q, prod_d;
  logic signed [AW-1:0]               acc_q, acc_d;

  logic [DW-1:0]                      dig;
  logic signed [DW:0]                 sdig;
  logic signed [dffc_pkg::PP_W-1:0]   pp;
  logic [PW-1:0]                      pp_ext;
  logic                               fits;

  assign dig    = sr_q[dffc_pkg::SMP_W-1 -: DW];
  assign sdig   = ctrl_i.first_dig ? $signed({dig[DW-1], dig}) : $signed({1'b0, dig});
  assign pp     = coef_q * sdig;
  assign pp_ext = {{(PW - dffc_pkg::PP_W){pp[dffc_pkg::PP_W-1]}}, pp};

  always_comb begin
    coef_d = coef_q;
    sr_d   = sr_q;
    prod_d = prod_q;
    acc_d  = acc_q;
    if (ctrl_i.mul) begin
      sr_d = {sr_q[dffc_pkg::SMP_W-DW-1:0], {DW{1'b0}}};
      if (ctrl_i.first_dig) begin
        prod_d = $signed(pp_ext);
      end else begin
        prod_d = $signed({prod_q[PW-DW-1:0], {DW{1'b0}}} + pp_ext);
      end
    end
    if (ctrl_i.load) begin
      coef_d = coef_i;
      sr_d   = smp_i;
    end
    if (ctrl_i.add) begin
      acc_d = acc_q + {{(AW - PW){prod_q[PW-1]}}, prod_q};
    end
    if (ctrl_i.clr) begin
      acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
    sr_q   <= sr_d;
    prod_q <= prod_d;
  end

  assign fits = (acc_q[AW-1:SW-1] == '0) || (acc_q[AW-1:SW-1] == '1);

  always_comb begin
    if (fits) begin
      sum_o = acc_q[SW-1:0];
    end else if (acc_q[AW-1]) begin
      sum_o = $signed({1'b1, {(SW - 1){1'b0}}});
    end else begin
      sum_o = $signed({1'b0, {(SW - 1){1'b1}}});
    end
  end

endmodule

`default_nettype wire

// ----- hdl/direct_form_fir_convolver_unit.sv -----
// direct_form_fir_convolver_unit: top level, sequencer, stores, mac and result register
// depends on dffc_pkg, dffc_if, dffc_store, dffc_mac
//
// channel  dir  payload                                                  transfer
// req_i    in   req_type coef_index coef_value sample_value first_sample valid & ready
// res_o    out  filtered_sum                                             valid & ready
//
// coefficient write: stored on transfer; coefficient indexes at or beyond TAPS are dropped
// sample: swept through all taps by the 4-bit digit-serial multiplier,
// four digit steps per tap on one shared mac
// reset clears all taps and the history through per-entry valid bits, no sweep
// a finished sum waits in the result register while the next item is taken; the
// sequencer holds its last state only while that register is still full
`default_nettype none

module direct_form_fir_convolver_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dffc_req_if.sink   req_i,
  dffc_res_if.source res_o
);

  localparam int unsigned IW = dffc_pkg::IDX_W;
  localparam int unsigned CW = dffc_pkg::DCNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_LD,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_e;

  state_e                            state_q;
  logic [IW-1:0]                     tap_q;
  logic [CW-1:0]                     dig_q;
  logic                              out_vld_q;
  logic signed [dffc_pkg::SUM_W-1:0] out_sum_q;

  dffc_pkg::store_ctrl_t             st_ctrl;
  dffc_pkg::mac_ctrl_t               mac_ctrl;
  logic signed [dffc_pkg::COEF_W-1:0] coef_rd;
  logic signed [dffc_pkg::SMP_W-1:0]  smp_rd;
  logic signed [dffc_pkg::SUM_W-1:0]  sum;

  logic                              req_xfer;
  logic                              res_xfer;
  logic [dffc_pkg::TCMP_W-1:0]       cidx_ext;
  logic                              cidx_ok;
  logic                              last_tap;
  logic                              last_dig;
  logic                              out_free;
  logic                              out_load;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign res_xfer    = res_o.valid && res_o.ready;

  assign cidx_ext = {{(dffc_pkg::TCMP_W - dffc_pkg::CIDX_W){1'b0}}, req_i.coef_index};
  assign cidx_ok  = cidx_ext < dffc_pkg::TCMP_W'(dffc_pkg::TAPS);
  assign last_tap = (tap_q == IW'(dffc_pkg::TAPS - 1));
  assign last_dig = (dig_q == CW'(dffc_pkg::NDIG - 1));
  assign out_free = !out_vld_q || res_o.ready;
  assign out_load = (state_q == ST_DONE) && out_free;

  always_comb begin
    st_ctrl          = '0;
    mac_ctrl         = '0;
    st_ctrl.rd_tap   = tap_q;
    st_ctrl.coef_we  = req_xfer && (req_i.req_type == dffc_pkg::REQ_COEF) && cidx_ok;
    st_ctrl.smp_we   = req_xfer && (req_i.req_type == dffc_pkg::REQ_SAMPLE);
    st_ctrl.hist_clr = req_i.first_sample[0];
    mac_ctrl.clr     = st_ctrl.smp_we;
    case (state_q)
      ST_RD: begin
        st_ctrl.rd_en = 1'b1;
      end
      ST_LD: begin
        mac_ctrl.load = 1'b1;
      end
      ST_MUL: begin
        mac_ctrl.mul       = 1'b1;
        mac_ctrl.first_dig = (dig_q == '0);
        mac_ctrl.add       = (dig_q == '0) && (tap_q != '0);
        // fetch the next tap on the second-to-last digit, load it on the last digit
        if ((dig_q == CW'(dffc_pkg::NDIG - 2)) && !last_tap) begin
          st_ctrl.rd_en  = 1'b1;
          st_ctrl.rd_tap = IW'(tap_q + 1'b1);
        end
        mac_ctrl.load = last_dig && !last_tap;
      end
      ST_SUM: begin
        mac_ctrl.add = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tap_q     <= '0;
      dig_q     <= '0;
      out_vld_q <= 1'b0;
      out_sum_q <= '0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
        out_sum_q <= sum;
      end else if (res_xfer) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (st_ctrl.smp_we) begin
            state_q <= ST_RD;
            tap_q   <= '0;
          end
        end
        ST_RD: begin
          state_q <= ST_LD;
        end
        ST_LD: begin
          state_q <= ST_MUL;
          dig_q   <= '0;
        end
        ST_MUL: begin
          dig_q <= CW'(dig_q + 1'b1);
          if (last_dig) begin
            if (last_tap) begin
              state_q <= ST_SUM;
            end else begin
              tap_q <= IW'(tap_q + 1'b1);
            end
          end
        end
        ST_SUM: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.filtered_sum = out_sum_q;

  dffc_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (st_ctrl),
    .coef_idx_i (cidx_ext[IW-1:0]),
    .coef_val_i (req_i.coef_value),
    .smp_val_i  (req_i.sample_value),
    .coef_rd_o  (coef_rd),
    .smp_rd_o   (smp_rd)
  );

  dffc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (coef_rd),
    .smp_i  (smp_rd),
    .sum_o  (sum)
  );

  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_ctrl.smp_we |=> (state_q == ST_RD) && (tap_q == '0))
    else $error("sample transfer did not start the tap sweep");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside the done state");

  a_sum_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> ($past(state_q) == ST_MUL) && $past(last_tap) && $past(last_dig))
    else $error("final add reached before the last tap digit");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_o.ready) |=> out_vld_q && $stable(out_sum_q))
    else $error("waiting result overwritten");

  a_no_coef_during_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !st_ctrl.coef_we && !st_ctrl.smp_we)
    else $error("store written while a sample is in progress");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// testbench for direct_form_fir_convolver_unit: a queued request driver, a result monitor
// and a convolution predictor that checks every filtered sum, over four pacing phases
// depends on dffc_pkg, dffc_if and the rtl top level
`default_nettype none

module testbench;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic                               req_type;
    logic [dffc_pkg::CIDX_W-1:0]        coef_index;
    logic signed [dffc_pkg::COEF_W-1:0] coef_value;
    logic signed [dffc_pkg::SMP_W-1:0]  sample_value;
    logic                               first_sample;
  } fir_req_t;

  logic clk_i;
  logic rst_ni;

  dffc_req_if req_bus ();
  dffc_res_if res_bus ();

  direct_form_fir_convolver_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .res_o  (res_bus)
  );

  fir_req_t                            req_queue[$];
  logic signed [dffc_pkg::SUM_W-1:0]   pending_sums[$];
  logic signed [dffc_pkg::COEF_W-1:0]  kernel[dffc_pkg::TAPS] = '{default: '0};
  logic signed [dffc_pkg::SMP_W-1:0]   history[dffc_pkg::TAPS] = '{default: '0};

  int send_idle_pct;
  int recv_stall_pct;
  int n_coef_writes;
  int n_samples;
  int n_sums_checked;
  int n_errors;
  int idle_cycles;

  function automatic bit roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic signed [15:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_coef(input logic [dffc_pkg::CIDX_W-1:0] idx,
                           input logic signed [15:0] val);
    fir_req_t it;
    it.req_type     = dffc_pkg::REQ_COEF;
    it.coef_index   = idx;
    it.coef_value   = val;
    it.sample_value = 16'($urandom);
    it.first_sample = 1'($urandom);
    req_queue.push_back(it);
  endtask

  task automatic push_sample(input logic signed [15:0] val, input logic first);
    fir_req_t it;
    it.req_type     = dffc_pkg::REQ_SAMPLE;
    it.coef_index   = 6'($urandom);
    it.coef_value   = 16'($urandom);
    it.sample_value = val;
    it.first_sample = first;
    req_queue.push_back(it);
  endtask

  // whole kernel and whole history at one extreme, drives the sum to its largest magnitude
  task automatic push_full_kernel(input logic signed [15:0] cval,
                                  input logic signed [15:0] sval);
    for (int k = 0; k < dffc_pkg::TAPS; k++) push_coef(dffc_pkg::CIDX_W'(k), cval);
    push_sample(sval, 1'b1);
    for (int k = 1; k < dffc_pkg::TAPS + 3; k++) push_sample(sval, 1'b0);
  endtask

  task automatic gen_random(input int count);
    int made;
    int len;
    fir_req_t it;
    made = 0;
    while (made < count) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          len = $urandom_range(1, 8);
          for (int k = 0; k < len; k++) push_coef(6'($urandom), rand_word());
          made += len;
        end
        8: begin
          it.req_type     = 1'($urandom);
          it.coef_index   = 6'($urandom);
          it.coef_value   = 16'($urandom);
          it.sample_value = 16'($urandom);
          it.first_sample = 1'($urandom);
          req_queue.push_back(it);
          made += 1;
        end
        default: begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 24);
          push_sample(rand_word(), 1'b1);
          for (int k = 1; k < len; k++) begin
            if ($urandom_range(0, 29) == 0) push_coef(6'($urandom), rand_word());
            push_sample(rand_word(), 1'b0);
          end
          made += len;
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input logic signed [dffc_pkg::SUM_W-1:0] want,
                                 input logic signed [dffc_pkg::SUM_W-1:0] got);
    $display("[%0t] filtered_sum mismatch on sum %0d: expected %0d got %0d",
             $realtime, n_sums_checked, want, got);
    n_errors++;
  endtask

  task automatic convolve_item(input fir_req_t it);
    longint acc;
    longint sum_max;
    sum_max = (longint'(1) <<< (dffc_pkg::SUM_W - 1)) - 1;
    if (it.req_type == dffc_pkg::REQ_COEF) begin
      if (int'(it.coef_index) < dffc_pkg::TAPS) kernel[it.coef_index] = it.coef_value;
      n_coef_writes++;
    end else begin
      if (it.first_sample) for (int k = 0; k < dffc_pkg::TAPS; k++) history[k] = '0;
      for (int k = dffc_pkg::TAPS - 1; k > 0; k--) history[k] = history[k-1];
      history[0] = it.sample_value;
      acc = 0;
      for (int k = 0; k < dffc_pkg::TAPS; k++) acc += longint'(kernel[k]) * longint'(history[k]);
      if (acc > sum_max) acc = sum_max;
      if (acc < -sum_max - 1) acc = -sum_max - 1;
      pending_sums.push_back(acc[dffc_pkg::SUM_W-1:0]);
      n_samples++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid        <= 1'b0;
      req_bus.req_type     <= '0;
      req_bus.coef_index   <= '0;
      req_bus.coef_value   <= '0;
      req_bus.sample_value <= '0;
      req_bus.first_sample <= '0;
    end else if (!req_bus.valid || req_bus.ready) begin
      if (req_bus.valid && req_bus.ready) begin
        convolve_item(req_queue.pop_front());
      end
      if (req_queue.size() > 0 && !roll(send_idle_pct)) begin
        req_bus.valid        <= 1'b1;
        req_bus.req_type     <= req_queue[0].req_type;
        req_bus.coef_index   <= req_queue[0].coef_index;
        req_bus.coef_value   <= req_queue[0].coef_value;
        req_bus.sample_value <= req_queue[0].sample_value;
        req_bus.first_sample <= req_queue[0].first_sample;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (pending_sums.size() == 0) begin
          $display("[%0t] unexpected result %0d with no sample outstanding",
                   $realtime, res_bus.filtered_sum);
          n_errors++;
        end else begin
          if (res_bus.filtered_sum !== pending_sums[0])
            report_mismatch(pending_sums[0], res_bus.filtered_sum);
          void'(pending_sums.pop_front());
          n_sums_checked++;
        end
      end
      res_bus.ready <= !roll(recv_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d cycles without a transfer", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int send_pcts[4];
    int recv_pcts[4];
    send_pcts = '{0, 87, 0, 27};
    recv_pcts = '{0, 0, 87, 27};
    rst_ni         = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty kernel, extreme taps, history clears, ignored fields
    push_sample(16'sh7fff, 1'b0);
    push_coef(6'd0, 16'sh8000);
    push_coef(6'd63, 16'sh7fff);
    push_coef(6'd1, 16'sh7fff);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh0000, 1'b0);
    push_sample(16'shffff, 1'b1);
    push_sample(16'sh0001, 1'b0);
    push_coef(6'd0, 16'sh0001);
    push_sample(16'sh8000, 1'b1);
    push_coef(6'd62, 16'shffff);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b0);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      if (p == 0) push_full_kernel(16'sh8000, 16'sh8000);
      if (p == 3) push_full_kernel(16'sh8000, 16'sh7fff);
      gen_random(260);
      while (req_queue.size() > 0 || pending_sums.size() > 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
    end

    repeat (300) @(posedge clk_i);
    $display("covered %0d coefficient writes and %0d samples, %0d sums checked",
             n_coef_writes, n_samples, n_sums_checked);
    $display("pacing phases: free running, sender gaps, result stalls, both; %0d errors",
             n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
